// ===== rtl/core/bbn_pkg.sv =====
// Shared constants, types and state encoding for the bounding box normalizer.
package bbn_pkg;

    localparam int COORD_BITS    = 32;
    localparam int OUT_FRAC_BITS = 30;
    localparam int NORM_BITS     = 32;
    localparam int NUM_AXES      = 3;
    localparam int AXIS_BITS     = $clog2(NUM_AXES);
    // one overflow check, one integer bit, then the fraction bits
    localparam int DIV_STEPS     = OUT_FRAC_BITS + 2;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ucoord_t;
    typedef logic        [NORM_BITS-1:0]  norm_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam norm_t NORM_POS_SAT = {1'b0, {(NORM_BITS-1){1'b1}}};
    localparam norm_t NORM_NEG_SAT = {1'b1, {(NORM_BITS-1){1'b0}}};

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_APPLY   = 1'b1;

    // bit positions in the input tuser
    localparam int TUSER_MODE  = 0;
    localparam int TUSER_START = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH,
        ST_DIV,
        ST_DONE
    } bbn_state_t;

endpackage

// ===== rtl/core/bbn_bounds.sv =====
// Per-axis min/max tracking with half extent and center derivation.
module bbn_bounds
    import bbn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    update,
    input  logic    clear,
    input  coord_t  vtx  [NUM_AXES],
    output ucoord_t half [NUM_AXES],
    output coord_t  mid  [NUM_AXES]
);

    localparam int OPW = COORD_BITS + 1;

    coord_t lo_reg [NUM_AXES];
    coord_t hi_reg [NUM_AXES];
    coord_t lo_cur [NUM_AXES];
    coord_t hi_cur [NUM_AXES];

    logic           empty [NUM_AXES];
    logic [OPW-1:0] span  [NUM_AXES];
    logic [OPW-1:0] sum   [NUM_AXES];
    logic [OPW-1:0] adj   [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            lo_cur[i] = clear ? COORD_MAX : lo_reg[i];
            hi_cur[i] = clear ? COORD_MIN : hi_reg[i];
            empty[i]  = hi_reg[i] < lo_reg[i];
            span[i]   = {hi_reg[i][COORD_BITS-1], hi_reg[i]}
                      - {lo_reg[i][COORD_BITS-1], lo_reg[i]};
            sum[i]    = {hi_reg[i][COORD_BITS-1], hi_reg[i]}
                      + {lo_reg[i][COORD_BITS-1], lo_reg[i]};
            // round toward zero: bias negative sums by one before the shift
            adj[i]    = sum[i] + {{COORD_BITS{1'b0}}, sum[i][OPW-1]};
            half[i]   = empty[i] ? '0 : span[i][OPW-1:1];
            mid[i]    = empty[i] ? '0 : coord_t'(adj[i][OPW-1:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                lo_reg[i] <= COORD_MAX;
                hi_reg[i] <= COORD_MIN;
            end
        end
        else if (update)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                lo_reg[i] <= (vtx[i] < lo_cur[i]) ? vtx[i] : lo_cur[i];
                hi_reg[i] <= (vtx[i] > hi_cur[i]) ? vtx[i] : hi_cur[i];
            end
        end
    end

endmodule

// ===== rtl/core/bbn_div_seq.sv =====
// Serial restoring divider: signed (vtx - center) / scale in Q2.30, saturated.
module bbn_div_seq
    import bbn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  coord_t  vtx,
    input  coord_t  center,
    input  ucoord_t scale,
    output logic    done,
    output norm_t   quot
);

    localparam int OPW = COORD_BITS + 1;
    localparam logic [STEP_BITS-1:0] STEP_SAT  = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] STEP_INT  = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   neg_reg;
    logic                   sat_reg;
    logic [OUT_FRAC_BITS:0] q_reg;
    logic [OPW-1:0]         rem_reg;
    ucoord_t                div_reg;

    logic [OPW-1:0] diff_in;
    logic [OPW-1:0] mag_in;
    logic [OPW-1:0] op_a;
    logic [OPW-1:0] op_b;
    logic [OPW-1:0] sub;
    logic           ge;
    norm_t          q_ext;

    assign diff_in = {vtx[COORD_BITS-1], vtx} - {center[COORD_BITS-1], center};
    assign mag_in  = diff_in[OPW-1] ? (~diff_in + OPW'(1)) : diff_in;

    // the one compare/subtract unit, fed per step
    always_comb
    begin
        if (step_reg == STEP_SAT)
        begin
            op_a = rem_reg;
            op_b = {div_reg, 1'b0};
        end
        else if (step_reg == STEP_INT)
        begin
            op_a = rem_reg;
            op_b = {1'b0, div_reg};
        end
        else
        begin
            op_a = {rem_reg[COORD_BITS-1:0], 1'b0};
            op_b = {1'b0, div_reg};
        end
        ge  = op_a >= op_b;
        sub = op_a - op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_SAT;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_SAT && ge)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + STEP_BITS'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= diff_in[OPW-1];
            sat_reg <= 1'b0;
            q_reg   <= '0;
            rem_reg <= {1'b0, mag_in[COORD_BITS-1:0]};
            div_reg <= scale;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_SAT)
            begin
                sat_reg <= ge;
            end
            else
            begin
                q_reg   <= {q_reg[OUT_FRAC_BITS-1:0], ge};
                rem_reg <= ge ? sub : op_a;
            end
        end
    end

    assign q_ext = {{(NORM_BITS-OUT_FRAC_BITS-1){1'b0}}, q_reg};
    assign done  = done_reg;
    assign quot  = sat_reg ? (neg_reg ? NORM_NEG_SAT : NORM_POS_SAT)
                 : (neg_reg ? (~q_ext + NORM_BITS'(1)) : q_ext);

endmodule

// ===== rtl/core/bounding_box_normalize_unit.sv =====
// Top level of the bounding box center and uniform scale normalizer.
//
// Vertices (signed Q16.16 x, y, z in s_tdata) arrive in two passes, selected
// by s_tuser: mode 0 measures, mode 1 applies. A measure request widens the
// per-axis min/max and produces nothing, so a measure pass streams at one
// vertex per clock while no apply request is in work. start_req on a measure
// request clears the bounds first. start_req on an apply request latches the
// box center (max+min)/2 and the scale (largest half extent) from the
// current bounds. Every apply request returns one result: (v - center) /
// scale per axis in signed Q2.30 (rounded toward zero, saturated), the three
// current half extents in unsigned Q16.16, and a degenerate flag when the
// scale is zero (coordinates then read as zero). An apply request walks the
// block through accept, prep, then for each axis launch, 32 steps of the
// single shared restoring divider and capture, then the output load; an axis
// whose quotient saturates finishes its division after one step, and a
// degenerate request skips the divider. The output load waits while the
// previous result still sits unaccepted, which stretches the request by
// those stall cycles. s_tready is low while an apply request is in work.
// The result sits in an output register, so the next request is taken
// while it waits for m_tready.
module bounding_box_normalize_unit
    import bbn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [3*COORD_BITS-1:0]    s_tdata,  // coord_x, coord_y, coord_z
    input  logic [1:0]                 s_tuser,  // mode, start_req
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // norm_x, norm_y, norm_z, half_extent_x, half_extent_y, half_extent_z
    output logic [6*NORM_BITS-1:0]     m_tdata,
    output logic [0:0]                 m_tuser   // degenerate
);

    bbn_state_t state_reg;
    bbn_state_t state_next;

    // request fields held for the divide phase
    coord_t  vtx_reg    [NUM_AXES];
    logic    start_hold_reg;
    coord_t  center_reg [NUM_AXES];
    ucoord_t scale_reg;
    norm_t   norm_reg   [NUM_AXES];
    logic [AXIS_BITS-1:0] axis_reg;

    // output register
    logic                   out_valid_reg;
    logic [6*NORM_BITS-1:0] out_data_reg;
    logic                   out_degen_reg;

    coord_t  in_vtx [NUM_AXES];
    ucoord_t half   [NUM_AXES];
    coord_t  mid    [NUM_AXES];
    ucoord_t scale_new;
    ucoord_t scale_xy;

    logic  item_acc;
    logic  meas_upd;
    logic  apply_acc;
    logic  latch_en;
    logic  div_start;
    logic  div_done;
    logic  out_load;
    logic  out_free;
    logic  degen;
    logic  last_axis;
    norm_t div_quot;
    norm_t norm_out [NUM_AXES];

    assign in_vtx[0] = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign in_vtx[1] = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign in_vtx[2] = coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);

    assign item_acc  = s_tvalid && s_tready;
    assign meas_upd  = item_acc && (s_tuser[TUSER_MODE] == MODE_MEASURE);
    assign apply_acc = item_acc && (s_tuser[TUSER_MODE] == MODE_APPLY);
    assign out_free  = !out_valid_reg || m_tready;
    assign degen     = (scale_reg == '0);
    assign last_axis = (axis_reg == AXIS_BITS'(NUM_AXES - 1));

    bbn_bounds u_bounds (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (meas_upd),
        .clear  (s_tuser[TUSER_START]),
        .vtx    (in_vtx),
        .half   (half),
        .mid    (mid)
    );

    bbn_div_seq u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .vtx    (vtx_reg[axis_reg]),
        .center (center_reg[axis_reg]),
        .scale  (scale_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

    // largest half extent
    assign scale_xy  = (half[0] > half[1]) ? half[0] : half[1];
    assign scale_new = (half[2] > scale_xy) ? half[2] : scale_xy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (apply_acc)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = degen ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = last_axis ? ST_DONE : ST_LAUNCH;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready  = 1'b0;
        latch_en  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_PREP:   latch_en  = start_hold_reg;
            ST_LAUNCH: div_start = !degen;
            ST_DIV:    ;
            ST_DONE:   out_load  = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // center and scale survive across requests; reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                center_reg[i] <= '0;
            scale_reg <= '0;
        end
        else if (latch_en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                center_reg[i] <= mid[i];
            scale_reg <= scale_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axis_reg <= '0;
        else if (state_reg == ST_PREP)
            axis_reg <= '0;
        else if (state_reg == ST_DIV && div_done && !last_axis)
            axis_reg <= axis_reg + AXIS_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (apply_acc)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                vtx_reg[i] <= in_vtx[i];
            start_hold_reg <= s_tuser[TUSER_START];
        end
        if (state_reg == ST_DIV && div_done)
            norm_reg[axis_reg] <= div_quot;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            norm_out[i] = degen ? '0 : norm_reg[i];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= {half[2], half[1], half[0],
                              norm_out[2], norm_out[1], norm_out[0]};
            out_degen_reg <= degen;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_degen_reg;

endmodule

// ===== bench/bounding_box_normalize_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bounding box normalizer: measure and apply passes against a predictor.
module bounding_box_normalize_unit_tb;
    import bbn_pkg::*;

    localparam int     TOTAL_ITEMS  = 1600;
    localparam int     MAX_GAP      = 10;
    // long receiver hold-off, started once this many results have been checked
    localparam int     HOLD_AFTER   = 150;
    localparam int     HOLD_CYCLES  = 1500;
    // long enough for a last apply request to finish, with margin to spare
    localparam int     DRAIN_CYCLES = 150;
    // ~1700 items at worst case each, plus the hold-off, several times over
    localparam longint CYCLE_LIMIT  = 1_000_000;
    localparam int     SHOW_LIMIT   = 10;

    // x in the low bits, then y, then z: same packing as s_tdata
    typedef coord_t [NUM_AXES-1:0] vertex_t;

    typedef struct packed {
        logic                   degenerate;
        ucoord_t [NUM_AXES-1:0] half;
        norm_t   [NUM_AXES-1:0] norm;
    } norm_result_t;

    // Tracks bounds, latched center and scale, and queues the result that
    // each apply request must produce.
    class bbox_scoreboard;
        longint          low [NUM_AXES];
        longint          high [NUM_AXES];
        longint          center [NUM_AXES];
        longint unsigned scale;
        norm_result_t    pending_results [$];
        int              mismatches;
        int              checked;
        string           axis_tag [NUM_AXES] = '{"x", "y", "z"};

        function new();
            clear_bounds();
            for (int a = 0; a < NUM_AXES; a++)
                center[a] = 0;
            scale      = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void clear_bounds();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                low[a]  = COORD_MAX;
                high[a] = COORD_MIN;
            end
        endfunction

        // empty axis (nothing measured) reads as zero extent
        function longint unsigned half_extent(int a);
            if (high[a] < low[a])
                return 0;
            return (high[a] - low[a]) >> 1;
        endfunction

        // (v - c) / s in Q2.30, truncated toward zero, saturated; s > 0
        function norm_t scaled_coord(longint v, longint c, longint unsigned s);
            longint          diff;
            bit              neg;
            longint unsigned mag;
            longint unsigned quo;
            longint unsigned rem;
            diff = v - c;
            neg  = diff < 0;
            mag  = neg ? -diff : diff;
            quo  = mag / s;
            rem  = mag % s;
            if (quo >= 2)
                return neg ? NORM_NEG_SAT : NORM_POS_SAT;
            for (int i = 0; i < OUT_FRAC_BITS; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= s)
                begin
                    rem = rem - s;
                    quo = quo | 1;
                end
            end
            if (neg)
                return norm_t'(-quo);
            if (quo > 64'h7FFF_FFFF)
                return NORM_POS_SAT;
            return norm_t'(quo);
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function void note_vertex(logic mode, logic start, vertex_t v);
            longint          vv [NUM_AXES];
            longint unsigned h [NUM_AXES];
            longint unsigned widest;
            norm_result_t    r;
            for (int a = 0; a < NUM_AXES; a++)
                vv[a] = longint'($signed(v[a]));
            if (mode == MODE_MEASURE)
            begin
                if (start)
                    clear_bounds();
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if (vv[a] > high[a])
                        high[a] = vv[a];
                    if (vv[a] < low[a])
                        low[a] = vv[a];
                end
                return;
            end
            widest = 0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                h[a] = half_extent(a);
                if (h[a] > widest)
                    widest = h[a];
            end
            if (start)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                    center[a] = (high[a] < low[a]) ? 0 : (low[a] + high[a]) / 2;
                scale = widest;
            end
            r.degenerate = (scale == 0);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                r.norm[a] = (scale == 0) ? '0 : scaled_coord(vv[a], center[a], scale);
                r.half[a] = ucoord_t'(h[a]);
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [6*NORM_BITS-1:0] data, logic degenerate);
            norm_result_t want;
            norm_t        got;
            checked++;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("result %0d with no request pending", checked),
                     0, data[NORM_BITS-1:0]);
                return;
            end
            want = pending_results.pop_front();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                got = data[a*NORM_BITS +: NORM_BITS];
                if (got !== want.norm[a])
                    flag($sformatf("result %0d norm_%s", checked, axis_tag[a]),
                         want.norm[a], got);
                got = data[(NUM_AXES+a)*NORM_BITS +: NORM_BITS];
                if (got !== want.half[a])
                    flag($sformatf("result %0d half_extent_%s", checked, axis_tag[a]),
                         want.half[a], got);
            end
            if (degenerate !== want.degenerate)
                flag($sformatf("result %0d degenerate", checked),
                     want.degenerate, degenerate);
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [3*COORD_BITS-1:0] s_tdata  = '0;   // coord_x, coord_y, coord_z
    logic [1:0]              s_tuser  = '0;   // mode, start_req
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // norm_x, norm_y, norm_z, half_extent_x, half_extent_y, half_extent_z
    logic [6*NORM_BITS-1:0]  m_tdata;
    logic [0:0]              m_tuser;         // degenerate

    bbox_scoreboard sb = new();
    int             items_sent  = 0;
    longint         cycle_count = 0;
    bit             send_burst  = 1'b0;
    bit             recv_burst  = 1'b0;

    bounding_box_normalize_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounding_box_normalize_unit regression: fail");
            $finish;
        end
    end

    function automatic vertex_t vtx(coord_t x, coord_t y, coord_t z);
        vertex_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        return v;
    endfunction

    // Flavors: 0 full 32-bit random, 1 within 32 units of Q16.16 around zero,
    // 2 corner values, 3 within 6 LSBs of zero (hits center rounding edges).
    function automatic coord_t pick_coord(int flavor);
        case (flavor)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h003F_FFFF)) - coord_t'(32'h0020_0000);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
            default: return coord_t'($urandom_range(0, 12)) - coord_t'(6);
        endcase
    endfunction

    function automatic vertex_t pick_vertex(int flavor);
        vertex_t v;
        for (int a = 0; a < NUM_AXES; a++)
            v[a] = pick_coord(flavor);
        return v;
    endfunction

    // Apply vertices: mostly inside the measured box, box corners often, some
    // pushed by over half its span, often out of it, and a few anywhere.
    function automatic vertex_t pick_apply_vertex(int flavor);
        vertex_t v;
        longint  span;
        longint  val;
        int      sel;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            span = sb.high[a] - sb.low[a];
            sel  = $urandom_range(0, 19);
            if (span < 0 || sel >= 17)
                v[a] = pick_coord(flavor);
            else
            begin
                if (sel < 2)
                    val = sb.low[a];
                else if (sel < 4)
                    val = sb.high[a];
                else
                    val = sb.low[a] + longint'({$urandom, $urandom} % (span + 1));
                if (sel >= 14)
                    val = $urandom_range(0, 1) ? val + span / 2 + 1 : val - span / 2 - 1;
                v[a] = coord_t'(val);
            end
        end
        return v;
    endfunction

    // Offer one request after a random gap; returns once it is accepted.
    // valid stays high across back-to-back requests (gap of zero).
    task automatic send_vertex(logic mode, logic start, vertex_t v);
        int         gap;
        logic [1:0] user;
        user              = '0;
        user[TUSER_MODE]  = mode;
        user[TUSER_START] = start;
        if ($urandom_range(0, 29) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= user;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_vertex(mode, start, v);
        items_sent++;
    endtask

    // Result side: random stalls, bursts with none, and one long hold-off
    // that backs the block up until s_tready drops.
    initial
    begin
        int gap;
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (!held_off && sb.checked >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                gap      = HOLD_CYCLES;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    initial
    begin
        int kind;
        int flavor;
        int n;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // apply with nothing measured: reset bounds are empty, scale stays zero
        send_vertex(MODE_APPLY, 1'b0, vtx(1, 2, 3));
        send_vertex(MODE_APPLY, 1'b1, vtx(COORD_MAX, COORD_MIN, 0));
        // a single measured point: zero extent everywhere, degenerate
        send_vertex(MODE_MEASURE, 1'b1, vtx(32'sh0001_0000, -32'sh0002_0000, 7));
        send_vertex(MODE_APPLY, 1'b1, vtx(32'sh0001_0000, 0, 7));
        // whole coordinate range on every axis
        send_vertex(MODE_MEASURE, 1'b1, vtx(COORD_MIN, COORD_MIN, COORD_MIN));
        send_vertex(MODE_MEASURE, 1'b0, vtx(COORD_MAX, COORD_MAX, COORD_MAX));
        send_vertex(MODE_APPLY, 1'b1, vtx(COORD_MAX, COORD_MIN, 0));
        send_vertex(MODE_APPLY, 1'b0, vtx(-1, 1, COORD_MIN));
        // small box, flat y, odd sums so the center sits on a rounding edge
        send_vertex(MODE_MEASURE, 1'b1, vtx(-32'sh0001_0001, 32'sh0000_5000, -3));
        send_vertex(MODE_MEASURE, 1'b0, vtx(32'sh0003_0000, 32'sh0000_5000, 4));
        send_vertex(MODE_APPLY, 1'b1, vtx(32'sh0003_0000, 32'sh0000_5000, 4));
        send_vertex(MODE_APPLY, 1'b0, vtx(-32'sh0001_0001, 0, -3));
        // far outside the box: saturates both ways
        send_vertex(MODE_APPLY, 1'b0, vtx(COORD_MAX, COORD_MIN, 32'sh0010_0000));
        send_vertex(MODE_APPLY, 1'b0, vtx(COORD_MIN, COORD_MAX, -32'sh0010_0000));
        // bounds grow after the latch: extents follow, center and scale hold
        send_vertex(MODE_MEASURE, 1'b0, vtx(32'sh0100_0000, -32'sh0100_0000, 0));
        send_vertex(MODE_APPLY, 1'b0, vtx(32'sh0002_0000, 32'sh0000_5000, 1));
        send_vertex(MODE_APPLY, 1'b1, vtx(32'sh0002_0000, 32'sh0000_5000, 1));
        // measure start in the middle of a pass drops the earlier points
        send_vertex(MODE_MEASURE, 1'b0, vtx(5, 5, 5));
        send_vertex(MODE_MEASURE, 1'b1, vtx(-5, -5, -5));
        send_vertex(MODE_MEASURE, 1'b0, vtx(5, 5, 5));
        send_vertex(MODE_APPLY, 1'b1, vtx(0, -5, 5));
        send_vertex(MODE_APPLY, 1'b0, vtx(6, -6, 3));

        // --- random ---
        // mostly measure pass then apply pass; some with a late widening and
        // an unlatched apply; the rest is noise with random mode and start
        while (items_sent < TOTAL_ITEMS)
        begin
            kind   = $urandom_range(0, 9);
            flavor = $urandom_range(0, 3);
            if (kind < 8)
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_vertex(MODE_MEASURE, i == 0, pick_vertex(flavor));
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_vertex(MODE_APPLY, i == 0, pick_apply_vertex(flavor));
                if (kind == 7)
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_vertex(MODE_MEASURE, 1'b0, pick_vertex($urandom_range(0, 3)));
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_vertex(MODE_APPLY, 1'b0, pick_apply_vertex(flavor));
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_vertex(logic'($urandom_range(0, 1)), $urandom_range(0, 2) == 0,
                                pick_vertex($urandom_range(0, 3)));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then watch a while longer for stray results
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("bounding_box_normalize_unit regression: pass");
        else
            $display("bounding_box_normalize_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bbn_pkg.sv
rtl/core/bbn_bounds.sv
rtl/core/bbn_div_seq.sv
rtl/core/bounding_box_normalize_unit.sv
bench/bounding_box_normalize_unit_tb.sv
